// ----- design/mandelbrot_escape_with_derivative_defines.svh -----
// Assertion macros used by the checker file of the escape-time pixel unit.
`ifndef MANDELBROT_ESCAPE_WITH_DERIVATIVE_DEFINES_SVH
`define MANDELBROT_ESCAPE_WITH_DERIVATIVE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MANDESC_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MANDESC_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/mandesc_pkg.sv -----
// Shared types, constants and the micro-operation table of the escape-time pixel unit.
package mandesc_pkg;

   localparam int CoordWidth  = 64;
   localparam int FracBits    = 32;
   localparam int IterWidth   = 16;
   localparam int DimWidth    = 12;
   localparam int SizeWidth   = 13;
   localparam int EpsWidth    = 63;
   localparam int WideWidth   = 2 * CoordWidth;
   localparam int HalfWidth   = CoordWidth / 2;
   localparam int DenWidth    = SizeWidth + 1;
   localparam int DivCntWidth = $clog2(WideWidth);
   localparam int CsrIdxWidth = 3;
   localparam int UopIdxWidth = 4;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [WideWidth-1:0]  wide_type;

   // Fixed-point constants.
   localparam coord_type FixOne    = 64'sh0000_0001_0000_0000;
   localparam coord_type FixNegOne = 64'shFFFF_FFFF_0000_0000;
   localparam coord_type EscapeThr = 64'sh000F_4240_0000_0000;
   localparam coord_type CoordMax  = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam coord_type CoordMin  = 64'sh8000_0000_0000_0000;
   localparam logic signed [IterWidth:0] IterNone = '1;

   // Register reset values.
   localparam coord_type LeftXRst   = 64'shFFFF_FFFD_8000_0000;
   localparam coord_type BottomYRst = 64'shFFFF_FFFE_8000_0000;
   localparam coord_type RightXRst  = 64'sh0000_0001_0000_0000;
   localparam coord_type TopYRst    = 64'sh0000_0001_8000_0000;
   localparam logic [SizeWidth-1:0] WidthRst  = 13'd1024;
   localparam logic [SizeWidth-1:0] HeightRst = 13'd768;
   localparam logic [IterWidth-1:0] MaxIterRst = 16'd256;
   localparam logic [EpsWidth-1:0]  EpsRst     = 63'd4294967;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_LEFT_X       = 3'd0,
      CSR_BOTTOM_Y     = 3'd1,
      CSR_RIGHT_X      = 3'd2,
      CSR_TOP_Y        = 3'd3,
      CSR_WIDTH_PX     = 3'd4,
      CSR_HEIGHT_PX    = 3'd5,
      CSR_MAX_ITER     = 3'd6,
      CSR_INTERIOR_EPS = 3'd7
   } csr_idx_type;

   // Multiplier operand sources.
   typedef enum logic [2:0] {
      OPD_X, OPD_Y, OPD_DX, OPD_DY, OPD_LO, OPD_HI, OPD_K, OPD_EPS
   } opd_type;

   // What an accumulator does with a finished product.
   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
   } acc_type;

   // Which result register takes a rounded accumulator value.
   typedef enum logic [2:0] {
      CAP_NONE, CAP_EPSQ, CAP_MOD_NX, CAP_DMOD, CAP_NDX_NDY, CAP_NY
   } cap_type;

   typedef struct packed {
      opd_type a;
      opd_type b;
      acc_type acc0;
      acc_type acc1;
      cap_type cap;
      logic    last;
   } uop_type;

   // Micro-operation addresses.
   localparam logic [UopIdxWidth-1:0] UopMapHi = 4'd0;
   localparam logic [UopIdxWidth-1:0] UopMapLo = 4'd1;
   localparam logic [UopIdxWidth-1:0] UopEps   = 4'd2;
   localparam logic [UopIdxWidth-1:0] UopXX    = 4'd3;
   localparam logic [UopIdxWidth-1:0] UopYY    = 4'd4;
   localparam logic [UopIdxWidth-1:0] UopDXDX  = 4'd5;
   localparam logic [UopIdxWidth-1:0] UopDYDY  = 4'd6;
   localparam logic [UopIdxWidth-1:0] UopDXX   = 4'd7;
   localparam logic [UopIdxWidth-1:0] UopDYY   = 4'd8;
   localparam logic [UopIdxWidth-1:0] UopXDY   = 4'd9;
   localparam logic [UopIdxWidth-1:0] UopDXY   = 4'd10;
   localparam logic [UopIdxWidth-1:0] UopXY    = 4'd11;

   // Product sequence: mapping, epsilon square, magnitudes, then the update.
   function automatic uop_type uop_rom(input logic [UopIdxWidth-1:0] idx);
      uop_type u;
      u = '{OPD_X, OPD_X, ACC_HOLD, ACC_HOLD, CAP_NONE, 1'b1};
      unique case (idx)
         UopMapHi: u = '{OPD_HI, OPD_K, ACC_LOAD, ACC_HOLD, CAP_NONE, 1'b0};
         UopMapLo: u = '{OPD_LO, OPD_K, ACC_SUB, ACC_HOLD, CAP_NONE, 1'b1};
         UopEps:   u = '{OPD_EPS, OPD_EPS, ACC_LOAD, ACC_HOLD, CAP_EPSQ, 1'b1};
         UopXX:    u = '{OPD_X, OPD_X, ACC_LOAD, ACC_LOAD, CAP_NONE, 1'b0};
         UopYY:    u = '{OPD_Y, OPD_Y, ACC_ADD, ACC_SUB, CAP_MOD_NX, 1'b0};
         UopDXDX:  u = '{OPD_DX, OPD_DX, ACC_LOAD, ACC_HOLD, CAP_NONE, 1'b0};
         UopDYDY:  u = '{OPD_DY, OPD_DY, ACC_ADD, ACC_HOLD, CAP_DMOD, 1'b1};
         UopDXX:   u = '{OPD_DX, OPD_X, ACC_LOAD, ACC_HOLD, CAP_NONE, 1'b0};
         UopDYY:   u = '{OPD_DY, OPD_Y, ACC_SUB, ACC_HOLD, CAP_NONE, 1'b0};
         UopXDY:   u = '{OPD_X, OPD_DY, ACC_HOLD, ACC_LOAD, CAP_NONE, 1'b0};
         UopDXY:   u = '{OPD_DX, OPD_Y, ACC_HOLD, ACC_ADD, CAP_NDX_NDY, 1'b0};
         UopXY:    u = '{OPD_X, OPD_Y, ACC_LOAD, ACC_HOLD, CAP_NY, 1'b1};
         default:  u = '{OPD_X, OPD_X, ACC_HOLD, ACC_HOLD, CAP_NONE, 1'b1};
      endcase
      return u;
   endfunction

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic    item_load;
      logic    mul_start;
      uop_type uop;
      logic    div_start;
      logic    map_axis;
      logic    map_cap;
      logic    init;
      logic    commit;
      logic    out_load;
      logic    out_esc;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic more;
      logic escape;
      logic interior;
   } status_type;

endpackage

// ----- design/mandelbrot_escape_with_derivative.sv -----
// Top level of the escape-time pixel unit with derivative interior test.
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    req_col, req_row
//   rsp       out        rsp_valid/rsp_ready    rsp_escape_iter, rsp_escape_modulus,
//                                               rsp_c_real, rsp_c_imag
//   csr       in         csr_we                 csr_index, csr_wdata
//
// One item at a time. Every 64x64 product is formed from partial products on the shared 32x32
// multiplier; mapping one pixel needs four products and two 128-step divisions.
// Reset is synchronous and returns the registers to their default plot window.
// A finished item waits in the output register; the next item is accepted meanwhile.
module mandelbrot_escape_with_derivative (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [mandesc_pkg::DimWidth-1:0]       req_col,
   input  logic [mandesc_pkg::DimWidth-1:0]       req_row,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [mandesc_pkg::IterWidth:0] rsp_escape_iter,
   output logic signed [mandesc_pkg::CoordWidth-1:0] rsp_escape_modulus,
   output logic signed [mandesc_pkg::CoordWidth-1:0] rsp_c_real,
   output logic signed [mandesc_pkg::CoordWidth-1:0] rsp_c_imag,
   input  logic                                   csr_we,
   input  logic [mandesc_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [mandesc_pkg::CoordWidth-1:0]     csr_wdata
);

   mandesc_pkg::cmd_type    cmd;
   mandesc_pkg::status_type status;

   // Sequencer.
   mandesc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and storage.
   mandesc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_col            (req_col),
      .req_row            (req_row),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_escape_iter    (rsp_escape_iter),
      .rsp_escape_modulus (rsp_escape_modulus),
      .rsp_c_real         (rsp_c_real),
      .rsp_c_imag         (rsp_c_imag)
   );

endmodule

// ----- design/mandesc_mul.sv -----
// Sequential signed 64x64 multiplier built from one 32x32 partial product per cycle.
module mandesc_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  mandesc_pkg::coord_type a,
   input  mandesc_pkg::coord_type b,
   output logic                  done,
   output mandesc_pkg::wide_type prod
);

   localparam int CW = mandesc_pkg::CoordWidth;
   localparam int HW = mandesc_pkg::HalfWidth;
   localparam int WW = mandesc_pkg::WideWidth;

   logic          busy_ff;
   logic          done_ff;
   logic [2:0]    phase_ff;
   logic [CW-1:0] ma_ff;
   logic [CW-1:0] mb_ff;
   logic          neg_ff;
   logic [CW-1:0] pp_ff;
   logic [WW-1:0] sum_ff;
   mandesc_pkg::wide_type prod_ff;

   logic [HW-1:0] ah;
   logic [HW-1:0] bh;
   logic [CW-1:0] pp_in;
   logic [1:0]    pidx;
   logic [WW-1:0] pp_shift;
   logic [WW-1:0] sum_in;

   // Pick the halves for this phase and line up the previous partial product.
   always_comb begin
      ah       = phase_ff[1] ? ma_ff[CW-1:HW] : ma_ff[HW-1:0];
      bh       = phase_ff[0] ? mb_ff[CW-1:HW] : mb_ff[HW-1:0];
      pp_in    = ah * bh;
      pidx     = 2'(phase_ff - 3'd1);
      pp_shift = {{CW{1'b0}}, pp_ff};
      case (pidx)
         2'd0:    pp_shift = {{CW{1'b0}}, pp_ff};
         2'd3:    pp_shift = {pp_ff, {CW{1'b0}}};
         default: pp_shift = {{HW{1'b0}}, pp_ff, {HW{1'b0}}};
      endcase
      sum_in = sum_ff + pp_shift;
   end

   // Phase control: products in phases 0 to 3, sums in 1 to 4, sign in 5.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            phase_ff <= 3'd0;
         end else if (busy_ff) begin
            phase_ff <= phase_ff + 3'd1;
            if (phase_ff == 3'd5) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operand magnitudes, partial products and the running sum.
   always_ff @(posedge clock) begin
      if (start) begin
         ma_ff  <= a[CW-1] ? CW'(-a) : a;
         mb_ff  <= b[CW-1] ? CW'(-b) : b;
         neg_ff <= a[CW-1] ^ b[CW-1];
         sum_ff <= '0;
      end else if (busy_ff) begin
         if (phase_ff < 3'd4) begin
            pp_ff <= pp_in;
         end
         if (phase_ff >= 3'd1 && phase_ff <= 3'd4) begin
            sum_ff <= sum_in;
         end
         if (phase_ff == 3'd5) begin
            prod_ff <= neg_ff ? WW'(-sum_ff) : sum_ff;
         end
      end
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

// ----- design/mandesc_div.sv -----
// Restoring divider: signed 128-bit dividend by a small positive divisor, one bit per cycle.
module mandesc_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  mandesc_pkg::wide_type                 num,
   input  logic [mandesc_pkg::DenWidth-1:0]      den,
   output logic                                  done,
   output mandesc_pkg::wide_type                 quo
);

   localparam int WW = mandesc_pkg::WideWidth;
   localparam int DW = mandesc_pkg::DenWidth;
   localparam int NW = mandesc_pkg::DivCntWidth;

   logic          busy_ff;
   logic          fin_ff;
   logic          done_ff;
   logic [NW-1:0] cnt_ff;
   logic [WW-1:0] mag_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic          neg_ff;
   mandesc_pkg::wide_type quo_ff;

   logic [DW:0]   rem_sh;
   logic          ge;
   logic [DW-1:0] rem_in;
   logic [WW-1:0] mag_in;

   // One quotient bit: shift in the next dividend bit and try the subtract.
   always_comb begin
      rem_sh = {rem_ff, mag_ff[WW-1]};
      ge     = rem_sh >= {1'b0, den_ff};
      rem_in = ge ? DW'(rem_sh - {1'b0, den_ff}) : DW'(rem_sh);
      mag_in = {mag_ff[WW-2:0], ge};
   end

   // Step counter and completion.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            fin_ff  <= 1'b0;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (fin_ff) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + NW'(1);
               if (cnt_ff == NW'(WW - 1)) begin
                  fin_ff <= 1'b1;
               end
            end
         end
      end
   end

   // Dividend magnitude, remainder and the signed quotient.
   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= num[WW-1] ? WW'(-num) : num;
         neg_ff <= num[WW-1];
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         if (fin_ff) begin
            quo_ff <= neg_ff ? WW'(-mag_ff) : mag_ff;
         end else begin
            mag_ff <= mag_in;
            rem_ff <= rem_in;
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ----- design/mandesc_datapath.sv -----
// Datapath: configuration registers, pixel mapping, iteration registers and result registers.
module mandesc_datapath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  mandesc_pkg::cmd_type                      cmd,
   output mandesc_pkg::status_type                   status,
   input  logic [mandesc_pkg::DimWidth-1:0]          req_col,
   input  logic [mandesc_pkg::DimWidth-1:0]          req_row,
   input  logic                                      csr_we,
   input  logic [mandesc_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [mandesc_pkg::CoordWidth-1:0]        csr_wdata,
   output logic signed [mandesc_pkg::IterWidth:0]    rsp_escape_iter,
   output mandesc_pkg::coord_type                    rsp_escape_modulus,
   output mandesc_pkg::coord_type                    rsp_c_real,
   output mandesc_pkg::coord_type                    rsp_c_imag
);

   localparam int CW = mandesc_pkg::CoordWidth;
   localparam int WW = mandesc_pkg::WideWidth;
   localparam int FB = mandesc_pkg::FracBits;
   localparam int DM = mandesc_pkg::DimWidth;
   localparam int SW = mandesc_pkg::SizeWidth;
   localparam int IW = mandesc_pkg::IterWidth;
   localparam int EW = mandesc_pkg::EpsWidth;

   // Saturate a wide signed value to the coordinate range.
   function automatic mandesc_pkg::coord_type sat_wide(input mandesc_pkg::wide_type v);
      mandesc_pkg::coord_type r;
      if ((&v[WW-1:CW-1]) || !(|v[WW-1:CW-1])) begin
         r = v[CW-1:0];
      end else begin
         r = v[WW-1] ? mandesc_pkg::CoordMin : mandesc_pkg::CoordMax;
      end
      return r;
   endfunction

   // Sign-extend a coordinate to the wide width.
   function automatic mandesc_pkg::wide_type sext(input mandesc_pkg::coord_type v);
      return {{CW{v[CW-1]}}, v};
   endfunction

   // Configuration registers.
   mandesc_pkg::coord_type left_x_ff, bottom_y_ff, right_x_ff, top_y_ff;
   logic [SW-1:0] width_ff, height_ff;
   logic [IW-1:0] max_iter_ff;
   logic [EW-1:0] eps_ff;

   // Item and iteration registers.
   logic [DM-1:0] col_ff, row_ff;
   mandesc_pkg::coord_type cr_ff, ci_ff;
   mandesc_pkg::coord_type x_ff, y_ff, dx_ff, dy_ff;
   mandesc_pkg::coord_type nx_ff, ny_ff, ndx_ff, ndy_ff;
   mandesc_pkg::coord_type mod_ff, dmod_ff, epsq_ff;
   logic [IW-1:0] it_ff;
   mandesc_pkg::wide_type acc0_ff, acc1_ff;
   mandesc_pkg::wide_type acc0_in, acc1_in;
   mandesc_pkg::cap_type cap_ff;

   // Result registers.
   logic signed [IW:0] esc_iter_ff;
   mandesc_pkg::coord_type emod_ff, out_cr_ff, out_ci_ff;

   // Multiplier and divider links.
   mandesc_pkg::coord_type opa, opb;
   logic                   mul_done;
   mandesc_pkg::wide_type  mul_prod;
   logic                   div_done;
   mandesc_pkg::wide_type  div_quo;
   logic [SW-1:0]          size_nz;
   logic [mandesc_pkg::DenWidth-1:0] den;
   mandesc_pkg::coord_type lo_val, hi_val, k_val;
   mandesc_pkg::coord_type nx_val, ny_val, c_val;

   // Operand selection for the shared multiplier.
   function automatic mandesc_pkg::coord_type opd_val(input mandesc_pkg::opd_type s,
                                                       input mandesc_pkg::coord_type lo,
                                                       input mandesc_pkg::coord_type hi,
                                                       input mandesc_pkg::coord_type k);
      mandesc_pkg::coord_type r;
      unique case (s)
         mandesc_pkg::OPD_X:   r = x_ff;
         mandesc_pkg::OPD_Y:   r = y_ff;
         mandesc_pkg::OPD_DX:  r = dx_ff;
         mandesc_pkg::OPD_DY:  r = dy_ff;
         mandesc_pkg::OPD_LO:  r = lo;
         mandesc_pkg::OPD_HI:  r = hi;
         mandesc_pkg::OPD_K:   r = k;
         mandesc_pkg::OPD_EPS: r = {1'b0, eps_ff};
         default:              r = x_ff;
      endcase
      return r;
   endfunction

   // Mapping operands: corner coordinates, odd pixel index and doubled image size.
   always_comb begin
      lo_val  = cmd.map_axis ? bottom_y_ff : left_x_ff;
      hi_val  = cmd.map_axis ? top_y_ff : right_x_ff;
      k_val   = {{(CW-DM-1){1'b0}}, (cmd.map_axis ? row_ff : col_ff), 1'b1};
      size_nz = cmd.map_axis ? height_ff : width_ff;
      if (size_nz == '0) begin
         size_nz = SW'(1);
      end
      den = {size_nz, 1'b0};
      opa = opd_val(cmd.uop.a, lo_val, hi_val, k_val);
      opb = opd_val(cmd.uop.b, lo_val, hi_val, k_val);
   end

   mandesc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (opa),
      .b     (opb),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   mandesc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (acc0_ff),
      .den   (den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Accumulators take each finished product as the micro-operation says.
   always_comb begin
      acc0_in = acc0_ff;
      acc1_in = acc1_ff;
      if (mul_done) begin
         case (cmd.uop.acc0)
            mandesc_pkg::ACC_LOAD: acc0_in = mul_prod;
            mandesc_pkg::ACC_ADD:  acc0_in = acc0_ff + mul_prod;
            mandesc_pkg::ACC_SUB:  acc0_in = acc0_ff - mul_prod;
            default:               acc0_in = acc0_ff;
         endcase
         case (cmd.uop.acc1)
            mandesc_pkg::ACC_LOAD: acc1_in = mul_prod;
            mandesc_pkg::ACC_ADD:  acc1_in = acc1_ff + mul_prod;
            mandesc_pkg::ACC_SUB:  acc1_in = acc1_ff - mul_prod;
            default:               acc1_in = acc1_ff;
         endcase
      end
   end

   // Rounded results: new z adds c after the floor shift; mapped c adds the low corner to the quotient.
   always_comb begin
      nx_val = sat_wide((acc1_ff >>> FB) + sext(cr_ff));
      ny_val = sat_wide((acc0_ff >>> (FB - 1)) + sext(ci_ff));
      c_val  = sat_wide(div_quo + sext(lo_val));
   end

   // A rounded value is captured in the cycle after its product finishes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= mandesc_pkg::CAP_NONE;
      end else begin
         cap_ff <= mul_done ? cmd.uop.cap : mandesc_pkg::CAP_NONE;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_x_ff   <= mandesc_pkg::LeftXRst;
         bottom_y_ff <= mandesc_pkg::BottomYRst;
         right_x_ff  <= mandesc_pkg::RightXRst;
         top_y_ff    <= mandesc_pkg::TopYRst;
         width_ff    <= mandesc_pkg::WidthRst;
         height_ff   <= mandesc_pkg::HeightRst;
         max_iter_ff <= mandesc_pkg::MaxIterRst;
         eps_ff      <= mandesc_pkg::EpsRst;
      end else if (csr_we) begin
         unique case (mandesc_pkg::csr_idx_type'(csr_index))
            mandesc_pkg::CSR_LEFT_X:       left_x_ff   <= csr_wdata;
            mandesc_pkg::CSR_BOTTOM_Y:     bottom_y_ff <= csr_wdata;
            mandesc_pkg::CSR_RIGHT_X:      right_x_ff  <= csr_wdata;
            mandesc_pkg::CSR_TOP_Y:        top_y_ff    <= csr_wdata;
            mandesc_pkg::CSR_WIDTH_PX:     width_ff    <= csr_wdata[SW-1:0];
            mandesc_pkg::CSR_HEIGHT_PX:    height_ff   <= csr_wdata[SW-1:0];
            mandesc_pkg::CSR_MAX_ITER:     max_iter_ff <= csr_wdata[IW-1:0];
            mandesc_pkg::CSR_INTERIOR_EPS: eps_ff      <= csr_wdata[EW-1:0];
            default:                       eps_ff      <= eps_ff;
         endcase
      end
   end

   // Working registers of one item.
   always_ff @(posedge clock) begin
      acc0_ff <= acc0_in;
      acc1_ff <= acc1_in;
      if (cmd.item_load) begin
         col_ff <= req_col;
         row_ff <= req_row;
      end
      if (cmd.map_cap) begin
         if (cmd.map_axis) begin
            ci_ff <= c_val;
         end else begin
            cr_ff <= c_val;
         end
      end
      case (cap_ff)
         mandesc_pkg::CAP_EPSQ: epsq_ff <= sat_wide(acc0_ff >>> FB);
         mandesc_pkg::CAP_MOD_NX: begin
            mod_ff <= sat_wide(acc0_ff >>> FB);
            nx_ff  <= nx_val;
         end
         mandesc_pkg::CAP_DMOD: dmod_ff <= sat_wide(acc0_ff >>> FB);
         mandesc_pkg::CAP_NDX_NDY: begin
            ndx_ff <= sat_wide(acc0_ff >>> (FB - 1));
            ndy_ff <= sat_wide(acc1_ff >>> (FB - 1));
         end
         mandesc_pkg::CAP_NY: ny_ff <= ny_val;
         default: ny_ff <= ny_ff;
      endcase
      if (cmd.init) begin
         x_ff  <= cr_ff;
         y_ff  <= ci_ff;
         dx_ff <= mandesc_pkg::FixOne;
         dy_ff <= '0;
         it_ff <= IW'(1);
      end else if (cmd.commit) begin
         x_ff  <= nx_ff;
         y_ff  <= ny_ff;
         dx_ff <= ndx_ff;
         dy_ff <= ndy_ff;
         it_ff <= it_ff + IW'(1);
      end
   end

   // Result registers, loaded when the output side is free.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         esc_iter_ff <= cmd.out_esc ? $signed({1'b0, it_ff}) : mandesc_pkg::IterNone;
         emod_ff     <= cmd.out_esc ? mod_ff : mandesc_pkg::FixNegOne;
         out_cr_ff   <= cr_ff;
         out_ci_ff   <= ci_ff;
      end
   end

   // Status for the controller.
   always_comb begin
      status.mul_done = mul_done;
      status.div_done = div_done;
      status.more     = it_ff < max_iter_ff;
      status.escape   = mandesc_pkg::EscapeThr < mod_ff;
      status.interior = dmod_ff < epsq_ff;
   end

   assign rsp_escape_iter    = esc_iter_ff;
   assign rsp_escape_modulus = emod_ff;
   assign rsp_c_real         = out_cr_ff;
   assign rsp_c_imag         = out_ci_ff;

endmodule

// ----- design/mandesc_ctrl.sv -----
// Controller: sequences mapping, products, exit checks and result hand-off for one item.
module mandesc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  mandesc_pkg::status_type status,
   output mandesc_pkg::cmd_type    cmd
);

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_MSTART    = 12'b0000_0000_0010,
      ST_MWAIT     = 12'b0000_0000_0100,
      ST_SETTLE    = 12'b0000_0000_1000,
      ST_DIV_START = 12'b0000_0001_0000,
      ST_DIV_WAIT  = 12'b0000_0010_0000,
      ST_MAPCAP    = 12'b0000_0100_0000,
      ST_INIT      = 12'b0000_1000_0000,
      ST_HEAD      = 12'b0001_0000_0000,
      ST_CHECK     = 12'b0010_0000_0000,
      ST_COMMIT    = 12'b0100_0000_0000,
      ST_DONE      = 12'b1000_0000_0000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic [mandesc_pkg::UopIdxWidth-1:0] uop_idx_ff, uop_idx_in;
   logic axis_ff, axis_in;
   logic esc_ff, esc_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      uop_idx_in   = uop_idx_ff;
      axis_in      = axis_ff;
      esc_in       = esc_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.uop      = mandesc_pkg::uop_rom(uop_idx_ff);
      cmd.map_axis = axis_ff;
      cmd.out_esc  = esc_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.item_load = 1'b1;
               axis_in       = 1'b0;
               uop_idx_in    = mandesc_pkg::UopMapHi;
               state_in      = ST_MSTART;
            end
         end
         ST_MSTART: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (status.mul_done) begin
               if (cmd.uop.last) begin
                  unique case (uop_idx_ff)
                     mandesc_pkg::UopMapLo: state_in = ST_DIV_START;
                     mandesc_pkg::UopEps:   state_in = ST_INIT;
                     default:               state_in = ST_SETTLE;
                  endcase
               end else begin
                  uop_idx_in = uop_idx_ff + mandesc_pkg::UopIdxWidth'(1);
                  state_in   = ST_MSTART;
               end
            end
         end
         ST_SETTLE: begin
            state_in = (uop_idx_ff == mandesc_pkg::UopDYDY) ? ST_CHECK : ST_COMMIT;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_MAPCAP;
            end
         end
         ST_MAPCAP: begin
            cmd.map_cap = 1'b1;
            state_in    = ST_MSTART;
            if (!axis_ff) begin
               axis_in    = 1'b1;
               uop_idx_in = mandesc_pkg::UopMapHi;
            end else begin
               uop_idx_in = mandesc_pkg::UopEps;
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            if (status.more) begin
               uop_idx_in = mandesc_pkg::UopXX;
               state_in   = ST_MSTART;
            end else begin
               esc_in   = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_CHECK: begin
            if (status.escape) begin
               esc_in   = 1'b1;
               state_in = ST_DONE;
            end else if (status.interior) begin
               esc_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               uop_idx_in = mandesc_pkg::UopDXX;
               state_in   = ST_MSTART;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_HEAD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         uop_idx_ff   <= mandesc_pkg::UopMapHi;
         axis_ff      <= 1'b0;
         esc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         uop_idx_ff   <= uop_idx_in;
         axis_ff      <= axis_in;
         esc_ff       <= esc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- design/mandesc_checker.sv -----
// Port-level checks of the escape-time pixel unit and their binding to the top level.
`include "mandelbrot_escape_with_derivative_defines.svh"

module mandesc_checker (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      rsp_valid,
   input logic                                      rsp_ready,
   input logic signed [mandesc_pkg::IterWidth:0]    rsp_escape_iter,
   input logic signed [mandesc_pkg::CoordWidth-1:0] rsp_escape_modulus
);

   // A stalled result item keeps its valid and its values.
   `MANDESC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_escape_iter) && $stable(rsp_escape_modulus), "stalled result item changed")

   // An item without escape reports minus one as its modulus.
   `MANDESC_ASSERT_NOW(a_none_modulus, rsp_valid && rsp_escape_iter == mandesc_pkg::IterNone, rsp_escape_modulus == mandesc_pkg::FixNegOne, "no-escape item has wrong modulus")

   // An escaped item names a step of at least one and a modulus above the bound.
   `MANDESC_ASSERT_NOW(a_escape_range, rsp_valid && rsp_escape_iter != mandesc_pkg::IterNone, rsp_escape_iter > 0 && rsp_escape_modulus > mandesc_pkg::EscapeThr, "escaped item out of range")

endmodule

bind mandelbrot_escape_with_derivative mandesc_checker u_mandesc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_escape_iter    (rsp_escape_iter),
   .rsp_escape_modulus (rsp_escape_modulus)
);
